### rtl/core/smm_pkg.sv
// Shared types, constants and helpers for the small matrix multiply block.
`default_nettype none
package smm_pkg;

  // default matrix sizes: A is ROWS x INNER, B is INNER x COLS
  localparam int unsigned ROWS_DEF  = 2;
  localparam int unsigned INNER_DEF = 3;
  localparam int unsigned COLS_DEF  = 7;

  localparam int unsigned IDX_W  = 3;   // row / column index width
  localparam int unsigned ELEM_W = 16;  // Q8.8 element
  localparam int unsigned PROD_W = 32;  // Q16.16 single term
  localparam int unsigned ACC_W  = 35;  // Q16.16 sum of up to eight terms

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } smm_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } smm_state_e;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;   // first term of a dot product
    logic             lastk;   // final term of a dot product
    logic             last;    // final element of the product matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } smm_tag_t;

  // address width for a store of the given depth, at least one bit
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

### rtl/core/smm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module smm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/smm_ctrl.sv
// Sequencer: walks row, column and inner index and issues store reads.
`default_nettype none
module smm_ctrl #(
  parameter int unsigned ROWS  = smm_pkg::ROWS_DEF,
  parameter int unsigned INNER = smm_pkg::INNER_DEF,
  parameter int unsigned COLS  = smm_pkg::COLS_DEF,
  parameter int unsigned AW_A  = 3,
  parameter int unsigned AW_B  = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             adv_i,
  output smm_pkg::smm_tag_t     issue_o,
  output logic [AW_A-1:0]       a_addr_o,
  output logic [AW_B-1:0]       b_addr_o
);
  import smm_pkg::*;

  smm_state_e       state_q, state_d;
  logic [IDX_W-1:0] i_q, j_q, k_q;
  logic             i_end, j_end, k_end;

  assign i_end = (i_q == IDX_W'(ROWS - 1));
  assign j_end = (j_q == IDX_W'(COLS - 1));
  assign k_end = (k_q == IDX_W'(INNER - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RUN;
      ST_RUN:  if (adv_i && i_end && j_end && k_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue_o       = '0;
    issue_o.first = (k_q == '0);
    issue_o.lastk = k_end;
    issue_o.last  = i_end && j_end;
    issue_o.row   = i_q;
    issue_o.col   = j_q;
    unique case (state_q)
      ST_IDLE: issue_o.valid = 1'b0;
      ST_RUN:  issue_o.valid = 1'b1;
      default: issue_o.valid = 1'b0;
    endcase
  end

  assign a_addr_o = AW_A'(i_q * INNER + k_q);
  assign b_addr_o = AW_B'(k_q * COLS + j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (adv_i) begin
        if (!k_end) begin
          k_q <= k_q + 1'b1;
        end else begin
          k_q <= '0;
          if (!j_end) begin
            j_q <= j_q + 1'b1;
          end else begin
            j_q <= '0;
            i_q <= i_end ? '0 : i_q + 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/smm_mac.sv
// Shared multiply-accumulate unit with product register and result register.
`default_nettype none
module smm_mac (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire smm_pkg::smm_tag_t            tag_i,
  input  wire logic signed [smm_pkg::ELEM_W-1:0] a_i,
  input  wire logic signed [smm_pkg::ELEM_W-1:0] b_i,
  output logic                              res_valid_o,
  output logic [smm_pkg::IDX_W-1:0]         res_row_o,
  output logic [smm_pkg::IDX_W-1:0]         res_col_o,
  output logic signed [smm_pkg::ACC_W-1:0]  res_value_o,
  output logic                              res_last_o
);
  import smm_pkg::*;

  smm_tag_t                  tag1_q, tag2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, sum;
  logic                      res_valid_q;
  logic [IDX_W-1:0]          res_row_q, res_col_q;
  logic signed [ACC_W-1:0]   res_value_q;
  logic                      res_last_q;

  // tag1 lines up with the store read data, tag2 with the product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      tag1_q      <= tag_i;
      tag2_q      <= tag1_q;
      res_valid_q <= tag2_q.valid && tag2_q.lastk;
    end
  end

  assign sum = (tag2_q.first ? ACC_W'(0) : acc_q)
             + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= a_i * b_i;
      if (tag2_q.valid) begin
        acc_q <= sum;
      end
      if (tag2_q.valid && tag2_q.lastk) begin
        res_row_q   <= tag2_q.row;
        res_col_q   <= tag2_q.col;
        res_value_q <= sum;
        res_last_q  <= tag2_q.last;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_row_o   = res_row_q;
  assign res_col_o   = res_col_q;
  assign res_value_o = res_value_q;
  assign res_last_o  = res_last_q;

endmodule
`default_nettype wire

### rtl/core/small_matrix_multiply.sv
// Top level of the small fixed-point matrix multiply engine.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  opcode_i row_index_i col_index_i value_i
//   out      output     out_valid_o / out_stall_i
//                                                out_row_o out_col_o product_value_o last_o
//
// Writes produce no word. A compute runs ROWS*COLS*INNER multiply-accumulate
// steps, one per cycle while the output is not stalled, on one shared unit;
// each step passes the store read register, the product register and the
// result register. Input stays stalled until the last word of the compute
// is taken; an output stall freezes the read/multiply/add pipe.
// Reset clears control only; the stores hold garbage until written.
`default_nettype none
module small_matrix_multiply #(
  parameter int unsigned ROWS  = smm_pkg::ROWS_DEF,
  parameter int unsigned INNER = smm_pkg::INNER_DEF,
  parameter int unsigned COLS  = smm_pkg::COLS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic [smm_pkg::IDX_W-1:0]           row_index_i,
  input  wire logic [smm_pkg::IDX_W-1:0]           col_index_i,
  input  wire logic signed [smm_pkg::ELEM_W-1:0]   value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [smm_pkg::IDX_W-1:0]                out_row_o,
  output logic [smm_pkg::IDX_W-1:0]                out_col_o,
  output logic signed [smm_pkg::ACC_W-1:0]         product_value_o,
  output logic                                     last_o
);
  import smm_pkg::*;

  localparam int unsigned DEPTH_A = ROWS * INNER;
  localparam int unsigned DEPTH_B = INNER * COLS;
  localparam int unsigned AW_A    = addr_w(DEPTH_A);
  localparam int unsigned AW_B    = addr_w(DEPTH_B);

  logic             in_fire, out_fire, adv;
  logic             busy_q;
  logic             row_ok_a, col_ok_a, row_ok_b, col_ok_b;
  logic             we_a, we_b, start;
  logic [AW_A-1:0]  a_waddr, a_raddr;
  logic [AW_B-1:0]  b_waddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  smm_tag_t         issue;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign adv      = !out_valid_o || !out_stall_i;
  assign in_stall_o = busy_q;

  assign row_ok_a = ({1'b0, row_index_i} < (IDX_W + 1)'(ROWS));
  assign col_ok_a = ({1'b0, col_index_i} < (IDX_W + 1)'(INNER));
  assign row_ok_b = ({1'b0, row_index_i} < (IDX_W + 1)'(INNER));
  assign col_ok_b = ({1'b0, col_index_i} < (IDX_W + 1)'(COLS));

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    unique case (smm_op_e'(opcode_i))
      OP_WR_A:    we_a  = in_fire && row_ok_a && col_ok_a;
      OP_WR_B:    we_b  = in_fire && row_ok_b && col_ok_b;
      OP_COMPUTE: start = in_fire;
      default:    start = 1'b0;
    endcase
  end

  assign a_waddr = AW_A'(row_index_i * INNER + col_index_i);
  assign b_waddr = AW_B'(row_index_i * COLS + col_index_i);

  // busy from a compute until its last word leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start) begin
      busy_q <= 1'b1;
    end else if (out_fire && last_o) begin
      busy_q <= 1'b0;
    end
  end

  smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH_A), .AW(AW_A)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (a_waddr),
    .wdata_i (value_i),
    .re_i    (adv),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH_B), .AW(AW_B)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (b_waddr),
    .wdata_i (value_i),
    .re_i    (adv),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  smm_ctrl #(
    .ROWS(ROWS), .INNER(INNER), .COLS(COLS), .AW_A(AW_A), .AW_B(AW_B)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .adv_i    (adv),
    .issue_o  (issue),
    .a_addr_o (a_raddr),
    .b_addr_o (b_raddr)
  );

  smm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tag_i       (issue),
    .a_i         (a_rdata),
    .b_i         (b_rdata),
    .res_valid_o (out_valid_o),
    .res_row_o   (out_row_o),
    .res_col_o   (out_col_o),
    .res_value_o (product_value_o),
    .res_last_o  (last_o)
  );

`ifndef ASSERT_OFF
  a_out_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_q)
    else $error("result word outside a compute");

  a_issue_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> busy_q)
    else $error("sequencer running while input is open");

  a_last_coord : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      (out_row_o == IDX_W'(ROWS - 1) && out_col_o == IDX_W'(COLS - 1)))
    else $error("last flag on wrong product element");
`endif

endmodule
`default_nettype wire
